### rtl/ssae_pkg.sv
// Shared constants, types and helper functions of the stretch sensor angle estimator.
`timescale 1ns / 1ps
`default_nettype none
package ssae_pkg;

  localparam int unsigned OVERSAMPLE     = 16;
  localparam int unsigned ADC_FULL_SCALE = 4096;
  localparam int unsigned ADC_W          = 12;
  localparam int unsigned ADC_MAX_CODE   = 4095;

  // Burst sum, span of the divider node and derived operand widths
  localparam int unsigned SUM_W   = $clog2(OVERSAMPLE * ADC_MAX_CODE + 1);
  localparam int unsigned CNT_W   = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1;
  localparam int unsigned SPAN    = OVERSAMPLE * ADC_FULL_SCALE;
  localparam int unsigned SPAN_W  = $clog2(SPAN + 1);
  localparam int unsigned SUM_LO  = OVERSAMPLE;
  localparam int unsigned SUM_HI  = OVERSAMPLE * (ADC_FULL_SCALE - 1);
  localparam int unsigned DEN_W   = $clog2(1000 * SPAN + 1);
  localparam int unsigned RFIX_W  = 20;
  localparam int unsigned NUM_W   = RFIX_W + SUM_W + 8;
  localparam int unsigned DVD_W   = NUM_W + 1;
  localparam int unsigned RES_W   = 24;
  localparam int unsigned ALPHA_W = 17;
  localparam int unsigned ANG_W   = 24;

  // Shared multiplier operand widths (signed)
  localparam int unsigned MUL_A_W = 21;
  localparam int unsigned MUL_B_W = 25;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // Horner state and accumulator widths
  localparam int unsigned HT_W  = 40;
  localparam int unsigned ACC_W = 64;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);
  localparam logic [9:0]         KOHM_DIV  = 10'd1000;

  localparam logic signed [HT_W-1:0] POLY_A0 = 40'sd25762065;
  localparam logic signed [HT_W-1:0] POLY_A1 = -40'sd41819307;
  localparam logic signed [HT_W-1:0] POLY_A2 = 40'sd23553649;
  localparam logic signed [HT_W-1:0] POLY_A3 = -40'sd4452909;
  localparam logic signed [ACC_W-1:0] HORNER_LIM = 64'sd274877906944;
  localparam logic signed [ACC_W-1:0] ANG_MAX    = 64'sd8388607;
  localparam logic signed [ACC_W-1:0] ANG_MIN    = -64'sd8388608;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_RES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_R_MIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_R_MAX     = 3'd3;
  localparam int unsigned CFG_DATA_W = 24;

  // Divider handshake toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Coefficient added after each Horner step, highest order first
  function automatic logic signed [HT_W-1:0] horner_coef(input logic [1:0] k);
    logic signed [HT_W-1:0] c;
    case (k)
      2'd0:    c = POLY_A2;
      2'd1:    c = POLY_A1;
      default: c = POLY_A0;
    endcase
    return c;
  endfunction

  // Divide by 256, rounding half away from zero
  function automatic logic signed [ACC_W-1:0] rnd256(input logic signed [ACC_W-1:0] p);
    logic signed [ACC_W-1:0] s;
    s = p + (p[ACC_W-1] ? 64'sd127 : 64'sd128);
    return s >>> 8;
  endfunction

endpackage
`default_nettype wire

### rtl/stretch_sensor_angle_estimator.sv
// Top level: burst accumulator, sequencer and datapath of the angle estimator.
`timescale 1ns / 1ps
`default_nettype none
// Takes one ADC word per cycle while in_ready_o is high and sums bursts of 16. The
// sixteenth word of a burst starts the conversion: sum to resistance (kilo-ohms Q16.8)
// through an iterative restoring divider that retires one quotient bit per cycle,
// then the moving average and a Horner cubic, all multiplications on one shared
// 21x25 multiplier. A burst end keeps in_ready_o low until the result is moved to the
// output register; the divider takes most of that time. All other words leave
// in_ready_o high. The result is held in an output register until taken, and
// configuration writes are taken in any cycle.
module stretch_sensor_angle_estimator (
  input  wire                                        clk_i,
  input  wire                                        rst_ni,
  input  wire                                        in_valid_i,
  output logic                                       in_ready_o,
  input  wire  logic [ssae_pkg::ADC_W-1:0]           adc_sample_i,
  output logic                                       out_valid_o,
  input  wire                                        out_ready_i,
  output logic [ssae_pkg::RES_W-1:0]                 resistance_kohm_q8_o,
  output logic signed [ssae_pkg::ANG_W-1:0]          angle_deg_q8_o,
  input  wire                                        cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire  logic [ssae_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire  logic [ssae_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_MUL_NUM   = 4'd1;
  localparam logic [3:0] S_MUL_DEN   = 4'd2;
  localparam logic [3:0] S_DIV_START = 4'd3;
  localparam logic [3:0] S_DIV_WAIT  = 4'd4;
  localparam logic [3:0] S_EMA_MUL   = 4'd5;
  localparam logic [3:0] S_EMA_ADD   = 4'd6;
  localparam logic [3:0] S_CLAMP     = 4'd7;
  localparam logic [3:0] S_H_LO      = 4'd8;
  localparam logic [3:0] S_H_HI      = 4'd9;
  localparam logic [3:0] S_H_ACC     = 4'd10;
  localparam logic [3:0] S_H_RND     = 4'd11;
  localparam logic [3:0] S_FINAL     = 4'd12;
  localparam logic [3:0] S_DONE      = 4'd13;

  localparam int unsigned EMA_W = 43;

  // configuration
  logic [ssae_pkg::RFIX_W-1:0]  rfix_q;
  logic [ssae_pkg::ALPHA_W-1:0] alpha_q;
  logic [ssae_pkg::RES_W-1:0]   rmin_q, rmax_q;

  // control
  logic [3:0]                   state_q, state_d;
  logic [ssae_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [1:0]                   k_q, k_d;
  logic                         primed_q, primed_d;
  logic                         out_valid_q, out_valid_d;

  // datapath
  logic [ssae_pkg::SUM_W-1:0]        sum_q, sum_d;
  logic [ssae_pkg::SUM_W-1:0]        sum_new;
  logic [ssae_pkg::SUM_W-1:0]        v_q, v_d;
  logic [ssae_pkg::NUM_W-9:0]        num_q, num_d;
  logic [ssae_pkg::DEN_W-1:0]        den_cur;
  logic [ssae_pkg::RES_W-1:0]        r_q, r_d;
  logic [ssae_pkg::RES_W-1:0]        s_q, s_d;
  logic [ssae_pkg::RES_W-1:0]        x_q, x_d;
  logic [ssae_pkg::RES_W-1:0]        x_lo;
  logic signed [ssae_pkg::HT_W-1:0]  t_q, t_d;
  logic signed [ssae_pkg::ACC_W-1:0] acc_q, acc_d;
  logic signed [ssae_pkg::ACC_W-1:0] h_sum, f_rnd;
  logic signed [EMA_W-1:0]           ema_sum;
  logic [ssae_pkg::RES_W-1:0]        res_out_q, res_out_d;
  logic signed [ssae_pkg::ANG_W-1:0] ang_q, ang_d;
  logic signed [ssae_pkg::ANG_W-1:0] ang_out_q, ang_out_d;
  logic [ssae_pkg::ALPHA_W-1:0]      alpha_c;
  logic [ssae_pkg::SPAN_W-1:0]       span_rem;

  // shared units
  logic signed [ssae_pkg::MUL_A_W-1:0] mul_a;
  logic signed [ssae_pkg::MUL_B_W-1:0] mul_b;
  logic signed [ssae_pkg::MUL_P_W-1:0] mul_p;
  logic                                div_start;
  logic [ssae_pkg::DVD_W-1:0]          div_dvd;
  ssae_pkg::div_stat_t                 div_stat;
  logic [ssae_pkg::RES_W-1:0]          div_quot;

  logic in_acc;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign alpha_c     = (alpha_q > ssae_pkg::ALPHA_ONE) ? ssae_pkg::ALPHA_ONE : alpha_q;
  assign span_rem    = ssae_pkg::SPAN_W'(ssae_pkg::SPAN) - ssae_pkg::SPAN_W'(v_q);
  assign den_cur     = ssae_pkg::DEN_W'(mul_p);
  assign div_dvd     = ssae_pkg::DVD_W'({num_q, 8'b0}) + ssae_pkg::DVD_W'(den_cur >> 1);
  assign div_start   = (state_q == S_DIV_START);

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MUL_NUM: begin
        mul_a = ssae_pkg::MUL_A_W'({1'b0, rfix_q});
        mul_b = ssae_pkg::MUL_B_W'({1'b0, v_q});
      end
      S_MUL_DEN: begin
        mul_a = ssae_pkg::MUL_A_W'({1'b0, ssae_pkg::KOHM_DIV});
        mul_b = ssae_pkg::MUL_B_W'({1'b0, span_rem});
      end
      S_EMA_MUL: begin
        mul_a = ssae_pkg::MUL_A_W'({1'b0, alpha_c});
        mul_b = $signed({1'b0, r_q}) - $signed({1'b0, s_q});
      end
      S_H_LO: begin
        mul_a = ssae_pkg::MUL_A_W'({1'b0, t_q[19:0]});
        mul_b = ssae_pkg::MUL_B_W'({1'b0, x_q});
      end
      S_H_HI: begin
        mul_a = ssae_pkg::MUL_A_W'($signed(t_q[ssae_pkg::HT_W-1:20]));
        mul_b = ssae_pkg::MUL_B_W'({1'b0, x_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  ssae_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  ssae_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (den_cur),
    .stat_o     (div_stat),
    .quot_o     (div_quot)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    primed_d    = primed_q;
    out_valid_d = out_valid_q;
    sum_d       = sum_q;
    v_d         = v_q;
    num_d       = num_q;
    r_d         = r_q;
    s_d         = s_q;
    x_d         = x_q;
    t_d         = t_q;
    acc_d       = acc_q;
    ang_d       = ang_q;
    res_out_d   = res_out_q;
    ang_out_d   = ang_out_q;
    sum_new     = sum_q + ssae_pkg::SUM_W'(adc_sample_i);
    ema_sum     = $signed({3'b0, s_q, 16'b0}) + EMA_W'(mul_p) + EMA_W'(32768);
    x_lo        = (s_q < rmin_q) ? rmin_q : s_q;
    h_sum       = ssae_pkg::rnd256(acc_q) + ssae_pkg::ACC_W'(ssae_pkg::horner_coef(k_q));
    f_rnd       = ssae_pkg::rnd256(ssae_pkg::ACC_W'(t_q));

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (cnt_q == ssae_pkg::CNT_W'(ssae_pkg::OVERSAMPLE - 1)) begin
            // clamp the burst sum and start the conversion
            if (sum_new < ssae_pkg::SUM_W'(ssae_pkg::SUM_LO)) begin
              v_d = ssae_pkg::SUM_W'(ssae_pkg::SUM_LO);
            end else if (sum_new > ssae_pkg::SUM_W'(ssae_pkg::SUM_HI)) begin
              v_d = ssae_pkg::SUM_W'(ssae_pkg::SUM_HI);
            end else begin
              v_d = sum_new;
            end
            sum_d   = '0;
            cnt_d   = '0;
            state_d = S_MUL_NUM;
          end else begin
            sum_d = sum_new;
            cnt_d = cnt_q + ssae_pkg::CNT_W'(1);
          end
        end
      end
      S_MUL_NUM: state_d = S_MUL_DEN;
      S_MUL_DEN: begin
        num_d   = (ssae_pkg::NUM_W - 8)'(mul_p);
        state_d = S_DIV_START;
      end
      S_DIV_START: state_d = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_stat.done) begin
          r_d = div_quot;
          if (primed_q) begin
            state_d = S_EMA_MUL;
          end else begin
            s_d      = div_quot;
            primed_d = 1'b1;
            state_d  = S_CLAMP;
          end
        end
      end
      S_EMA_MUL: state_d = S_EMA_ADD;
      S_EMA_ADD: begin
        s_d     = ema_sum[ssae_pkg::RES_W+15:16];
        state_d = S_CLAMP;
      end
      S_CLAMP: begin
        x_d     = (x_lo > rmax_q) ? rmax_q : x_lo;
        t_d     = ssae_pkg::POLY_A3;
        k_d     = '0;
        state_d = S_H_LO;
      end
      S_H_LO: state_d = S_H_HI;
      S_H_HI: begin
        acc_d   = ssae_pkg::ACC_W'(mul_p);
        state_d = S_H_ACC;
      end
      S_H_ACC: begin
        acc_d   = acc_q + (ssae_pkg::ACC_W'(mul_p) <<< 20);
        state_d = S_H_RND;
      end
      S_H_RND: begin
        // saturate each Horner step at +-2^38
        if (h_sum > ssae_pkg::HORNER_LIM) begin
          t_d = ssae_pkg::HT_W'(ssae_pkg::HORNER_LIM);
        end else if (h_sum < -ssae_pkg::HORNER_LIM) begin
          t_d = ssae_pkg::HT_W'(-ssae_pkg::HORNER_LIM);
        end else begin
          t_d = ssae_pkg::HT_W'(h_sum);
        end
        if (k_q == 2'd2) begin
          state_d = S_FINAL;
        end else begin
          k_d     = k_q + 2'd1;
          state_d = S_H_LO;
        end
      end
      S_FINAL: begin
        if (f_rnd > ssae_pkg::ANG_MAX) begin
          ang_d = ssae_pkg::ANG_W'(ssae_pkg::ANG_MAX);
        end else if (f_rnd < ssae_pkg::ANG_MIN) begin
          ang_d = ssae_pkg::ANG_W'(ssae_pkg::ANG_MIN);
        end else begin
          ang_d = ssae_pkg::ANG_W'(f_rnd);
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          res_out_d   = s_q;
          ang_out_d   = ang_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      k_q         <= '0;
      primed_q    <= 1'b0;
      out_valid_q <= 1'b0;
      sum_q       <= '0;
      s_q         <= '0;
      t_q         <= '0;
      rfix_q      <= ssae_pkg::RFIX_W'(10000);
      alpha_q     <= ssae_pkg::ALPHA_W'(13107);
      rmin_q      <= ssae_pkg::RES_W'(256);
      rmax_q      <= ssae_pkg::RES_W'(1024);
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      primed_q    <= primed_d;
      out_valid_q <= out_valid_d;
      sum_q       <= sum_d;
      s_q         <= s_d;
      t_q         <= t_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          ssae_pkg::REG_FIXED_RES: rfix_q  <= cfg_data_i[ssae_pkg::RFIX_W-1:0];
          ssae_pkg::REG_ALPHA:     alpha_q <= cfg_data_i[ssae_pkg::ALPHA_W-1:0];
          ssae_pkg::REG_R_MIN:     rmin_q  <= cfg_data_i[ssae_pkg::RES_W-1:0];
          ssae_pkg::REG_R_MAX:     rmax_q  <= cfg_data_i[ssae_pkg::RES_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    v_q       <= v_d;
    num_q     <= num_d;
    r_q       <= r_d;
    x_q       <= x_d;
    acc_q     <= acc_d;
    ang_q     <= ang_d;
    res_out_q <= res_out_d;
    ang_out_q <= ang_out_d;
  end

  assign out_valid_o          = out_valid_q;
  assign resistance_kohm_q8_o = res_out_q;
  assign angle_deg_q8_o       = ang_out_q;

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == S_DIV_WAIT)
    else $error("divider finished outside its wait state");

  a_idle_div_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !div_stat.busy)
    else $error("divider busy while accepting words");

  a_result_primed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> primed_q)
    else $error("result given before the average was loaded");

  a_horner_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ssae_pkg::ACC_W'(t_q) <= ssae_pkg::HORNER_LIM) &&
    (ssae_pkg::ACC_W'(t_q) >= -ssae_pkg::HORNER_LIM))
    else $error("Horner term out of range");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (cnt_q == ssae_pkg::CNT_W'(ssae_pkg::OVERSAMPLE - 1)) |=>
    (state_q == S_MUL_NUM) && (cnt_q == '0))
    else $error("burst end did not start a conversion");

endmodule
`default_nettype wire

### rtl/ssae_mul.sv
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none
module ssae_mul (
  input  wire                                         clk_i,
  input  wire  logic signed [ssae_pkg::MUL_A_W-1:0]   a_i,
  input  wire  logic signed [ssae_pkg::MUL_B_W-1:0]   b_i,
  output logic signed [ssae_pkg::MUL_P_W-1:0]         p_o
);

  logic signed [ssae_pkg::MUL_P_W-1:0] p_q, p_d;

  assign p_d = ssae_pkg::MUL_P_W'(a_i) * ssae_pkg::MUL_P_W'(b_i);

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

### rtl/ssae_div.sv
// Restoring divider, one quotient bit per cycle, quotient saturated to 24 bits.
`timescale 1ns / 1ps
`default_nettype none
module ssae_div (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  start_i,
  input  wire  logic [ssae_pkg::DVD_W-1:0]     dividend_i,
  input  wire  logic [ssae_pkg::DEN_W-1:0]     divisor_i,
  output ssae_pkg::div_stat_t                  stat_o,
  output logic [ssae_pkg::RES_W-1:0]           quot_o
);

  localparam int unsigned DCNT_W = $clog2(ssae_pkg::DVD_W + 1);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [DCNT_W-1:0]               cnt_q, cnt_d;
  logic [ssae_pkg::DEN_W-1:0]      rem_q, rem_d;
  logic [ssae_pkg::DEN_W-1:0]      den_q, den_d;
  logic [ssae_pkg::DVD_W-1:0]      dvd_q, dvd_d;
  logic [ssae_pkg::RES_W-1:0]      quo_q, quo_d;
  logic                            ovf_q, ovf_d;
  logic [ssae_pkg::DEN_W:0]        rem_sh;
  logic                            ge;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    ovf_d  = ovf_q;
    rem_sh = {rem_q, dvd_q[ssae_pkg::DVD_W-1]};
    ge     = rem_sh >= {1'b0, den_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DCNT_W'(ssae_pkg::DVD_W);
      rem_d  = '0;
      den_d  = divisor_i;
      dvd_d  = dividend_i;
      quo_d  = '0;
      ovf_d  = 1'b0;
    end else if (busy_q) begin
      rem_d = ge ? ssae_pkg::DEN_W'(rem_sh - {1'b0, den_q})
                 : ssae_pkg::DEN_W'(rem_sh);
      dvd_d = {dvd_q[ssae_pkg::DVD_W-2:0], 1'b0};
      // a bit leaving the top means the quotient no longer fits
      ovf_d = ovf_q | quo_q[ssae_pkg::RES_W-1];
      quo_d = {quo_q[ssae_pkg::RES_W-2:0], ge};
      cnt_d = cnt_q - DCNT_W'(1);
      if (cnt_q == DCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    ovf_q <= ovf_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = ovf_q ? {ssae_pkg::RES_W{1'b1}} : quo_q;

endmodule
`default_nettype wire
